>>> rtl/fgn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractal gradient noise package
// Shared types, widths, register indexes, the permutation table and the
// gradient dot product used by the octave cells.
// ----------------------------------------------------------------------------
package fgn_pkg;

	localparam int SX_W        = 40;
	localparam int FREQ_W      = 32;
	localparam int AMP_W       = 20;
	localparam int SUM_W       = 27;
	localparam int DOT_W       = 20;
	localparam int CELL_STAGES = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;

	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_0     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_1     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_2     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_3     = 3'd7;

	localparam logic [1:0] GRAD_PP = 2'd0;
	localparam logic [1:0] GRAD_NP = 2'd1;
	localparam logic [1:0] GRAD_PN = 2'd2;
	localparam logic [1:0] GRAD_NN = 2'd3;

	// Data handed from one octave cell to the next.
	typedef struct packed {
		logic                    valid;
		logic [SX_W-1:0]         sx;
		logic [SX_W-1:0]         sy;
		logic [FREQ_W-1:0]       freq;
		logic [AMP_W-1:0]        amp;
		logic signed [SUM_W-1:0] sum;
	} link_t;

	localparam logic [7:0] PERM_ROM [0:255] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
		8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
		8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
		8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
		8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
		8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
		8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
		8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
		8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
		8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
		8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
		8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
		8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
		8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
		8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
		8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
		8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
		8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
		8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
		8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
		8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
		8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

	// Dot product of a corner offset with one of four diagonal gradients.
	function automatic logic signed [DOT_W-1:0] grad_dot(
		input logic [1:0]              h,
		input logic signed [DOT_W-1:0] dx,
		input logic signed [DOT_W-1:0] dy
	);
		logic signed [DOT_W-1:0] r;
		case (h)
			GRAD_PP: r = dx + dy;
			GRAD_NP: r = dy - dx;
			GRAD_PN: r = dx - dy;
			GRAD_NN: r = -dx - dy;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/fgn_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point scaling stage
// Multiplies the sample point by the reciprocal noise scale and starts the
// octave chain with unit frequency, unit amplitude and an empty sum.
// ----------------------------------------------------------------------------
module fgn_scale (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic signed [31:0]  point_x,
	input  wire logic signed [31:0]  point_y,
	input  wire logic [23:0]         inverse_scale,
	output fgn_pkg::link_t           link_out
);

	logic              valid_s1;
	logic signed [56:0] px_s1;
	logic signed [56:0] py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= point_x * $signed({1'b0, inverse_scale});
			py_s1 <= point_y * $signed({1'b0, inverse_scale});
		end
	end

	always_comb begin
		link_out.valid = valid_s1;
		link_out.sx    = px_s1[55:16];
		link_out.sy    = py_s1[55:16];
		link_out.freq  = fgn_pkg::FREQ_W'(32'h0001_0000);
		link_out.amp   = fgn_pkg::AMP_W'(20'h1_0000);
		link_out.sum   = '0;
	end

endmodule
`default_nettype wire

>>> rtl/fgn_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Octave cell
// Evaluates one octave of lattice gradient noise for the point it receives,
// adds the weighted result to the running sum and hands the point on with
// the next frequency and amplitude.
// ----------------------------------------------------------------------------
module fgn_cell (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        active,
	input  wire logic [47:0] offset,
	input  wire logic [19:0] lacunarity,
	input  wire logic [16:0] persistence,
	input  wire fgn_pkg::link_t link_in,
	output fgn_pkg::link_t   link_out
);

	localparam int NS = fgn_pkg::CELL_STAGES;

	fgn_pkg::link_t carry_q [NS];
	logic [fgn_pkg::FREQ_W-1:0] fn_q [NS-1];
	logic [fgn_pkg::AMP_W-1:0]  an_q [NS-1];

	logic [51:0] mlo_x_s1, mlo_y_s1, fmul_s1;
	logic [19:0] mhi_x_s1, mhi_y_s1;
	logic [36:0] amul_s1;
	logic [23:0] cx_s2, cy_s2;
	logic [35:0] fpx_s3, fpy_s3;
	logic [7:0]  ra_s3, rb_s3, yi_s3;
	logic [15:0] fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fy_s5, fx_s6, fy_s6;
	logic [19:0] b0x_s4, b0y_s4;
	logic [1:0]  h00_s4, h01_s4, h10_s4, h11_s4;
	logic [35:0] p1x_s5, p1y_s5, p2x_s6, p2y_s6, p3x_s7, p3y_s7;
	logic signed [fgn_pkg::DOT_W-1:0] d00_s5, d01_s5, d10_s5, d11_s5;
	logic signed [fgn_pkg::DOT_W-1:0] d00_s6, d01_s6, d10_s6, d11_s6;
	logic signed [fgn_pkg::DOT_W-1:0] d00_s7, d01_s7, d10_s7, d11_s7;
	logic signed [fgn_pkg::DOT_W-1:0] d00_s8, d01_s8;
	logic signed [38:0] lp0_s8, lp1_s8, lp2_s10;
	logic [16:0] v_s8, v_s9;
	logic signed [fgn_pkg::DOT_W-1:0] x0_s9, x1_s9, x0_s10, val_s11;
	logic signed [40:0] term_s12;
	logic signed [fgn_pkg::SUM_W-1:0] sum_s13;

	logic [39:0] mhi_x, mhi_y, pos_x, pos_y;
	logic [19:0] apx, apy;
	logic [35:0] cex, cey;
	logic signed [fgn_pkg::DOT_W-1:0] dx0, dx1, dy0, dy1;
	logic signed [fgn_pkg::DOT_W:0]   dlo, dhi, dmid;

	always_comb begin
		mhi_x = {20'b0, link_in.sx[39:20]} * {20'b0, link_in.freq[19:0]};
		mhi_y = {20'b0, link_in.sy[39:20]} * {20'b0, link_in.freq[19:0]};
		pos_x = mlo_x_s1[39:0] + {mhi_x_s1, 20'b0};
		pos_y = mlo_y_s1[39:0] + {mhi_y_s1, 20'b0};
		apx   = 20'd983040 - ({4'b0, cx_s2[15:0]} * 20'd6);
		apy   = 20'd983040 - ({4'b0, cy_s2[15:0]} * 20'd6);
		// Round the first fade product up, as the polynomial expects.
		cex   = fpx_s3 + 36'h0_FFFF;
		cey   = fpy_s3 + 36'h0_FFFF;
		dx0   = $signed({4'b0, fx_s4});
		dy0   = $signed({4'b0, fy_s4});
		dx1   = dx0 - 20'sd65536;
		dy1   = dy0 - 20'sd65536;
		dlo   = {d10_s7[19], d10_s7} - {d00_s7[19], d00_s7};
		dhi   = {d11_s7[19], d11_s7} - {d01_s7[19], d01_s7};
		dmid  = {x1_s9[19], x1_s9} - {x0_s9[19], x0_s9};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				carry_q[i] <= '0;
			end
		end else if (en) begin
			carry_q[0] <= link_in;
			for (int i = 1; i < NS; i++) begin
				carry_q[i] <= carry_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: lattice position, next frequency and amplitude products.
			mlo_x_s1 <= {32'b0, link_in.sx[19:0]} * {20'b0, link_in.freq};
			mlo_y_s1 <= {32'b0, link_in.sy[19:0]} * {20'b0, link_in.freq};
			mhi_x_s1 <= mhi_x[19:0];
			mhi_y_s1 <= mhi_y[19:0];
			fmul_s1  <= {20'b0, link_in.freq} * {32'b0, lacunarity};
			amul_s1  <= {17'b0, link_in.amp} * {20'b0, persistence};
			// Stage 2: wrap onto the lattice.
			cx_s2    <= pos_x[39:16] + offset[47:24];
			cy_s2    <= pos_y[39:16] + offset[23:0];
			fn_q[0]  <= fmul_s1[47:16];
			an_q[0]  <= amul_s1[35:16];
			for (int i = 1; i < NS - 1; i++) begin
				fn_q[i] <= fn_q[i-1];
				an_q[i] <= an_q[i-1];
			end
			// Stage 3
			fpx_s3   <= {20'b0, cx_s2[15:0]} * {16'b0, apx};
			fpy_s3   <= {20'b0, cy_s2[15:0]} * {16'b0, apy};
			ra_s3    <= fgn_pkg::PERM_ROM[cx_s2[23:16]];
			rb_s3    <= fgn_pkg::PERM_ROM[8'(cx_s2[23:16] + 8'd1)];
			yi_s3    <= cy_s2[23:16];
			fx_s3    <= cx_s2[15:0];
			fy_s3    <= cy_s2[15:0];
			// Stage 4
			b0x_s4   <= 20'd655360 - cex[35:16];
			b0y_s4   <= 20'd655360 - cey[35:16];
			h00_s4   <= fgn_pkg::PERM_ROM[8'(ra_s3 + yi_s3)][1:0];
			h01_s4   <= fgn_pkg::PERM_ROM[8'(ra_s3 + yi_s3 + 8'd1)][1:0];
			h10_s4   <= fgn_pkg::PERM_ROM[8'(rb_s3 + yi_s3)][1:0];
			h11_s4   <= fgn_pkg::PERM_ROM[8'(rb_s3 + yi_s3 + 8'd1)][1:0];
			fx_s4    <= fx_s3;
			fy_s4    <= fy_s3;
			// Stage 5
			p1x_s5   <= {20'b0, fx_s4} * {16'b0, b0x_s4};
			p1y_s5   <= {20'b0, fy_s4} * {16'b0, b0y_s4};
			d00_s5   <= fgn_pkg::grad_dot(h00_s4, dx0, dy0);
			d01_s5   <= fgn_pkg::grad_dot(h01_s4, dx0, dy1);
			d10_s5   <= fgn_pkg::grad_dot(h10_s4, dx1, dy0);
			d11_s5   <= fgn_pkg::grad_dot(h11_s4, dx1, dy1);
			fx_s5    <= fx_s4;
			fy_s5    <= fy_s4;
			// Stage 6
			p2x_s6   <= {20'b0, fx_s5} * {16'b0, p1x_s5[35:16]};
			p2y_s6   <= {20'b0, fy_s5} * {16'b0, p1y_s5[35:16]};
			fx_s6    <= fx_s5;
			fy_s6    <= fy_s5;
			d00_s6   <= d00_s5;
			d01_s6   <= d01_s5;
			d10_s6   <= d10_s5;
			d11_s6   <= d11_s5;
			// Stage 7
			p3x_s7   <= {20'b0, fx_s6} * {16'b0, p2x_s6[35:16]};
			p3y_s7   <= {20'b0, fy_s6} * {16'b0, p2y_s6[35:16]};
			d00_s7   <= d00_s6;
			d01_s7   <= d01_s6;
			d10_s7   <= d10_s6;
			d11_s7   <= d11_s6;
			// Stage 8: blend along x.
			lp0_s8   <= $signed({1'b0, p3x_s7[32:16]}) * dlo;
			lp1_s8   <= $signed({1'b0, p3x_s7[32:16]}) * dhi;
			d00_s8   <= d00_s7;
			d01_s8   <= d01_s7;
			v_s8     <= p3y_s7[32:16];
			// Stage 9
			x0_s9    <= d00_s8 + $signed(lp0_s8[35:16]);
			x1_s9    <= d01_s8 + $signed(lp1_s8[35:16]);
			v_s9     <= v_s8;
			// Stage 10: blend along y.
			lp2_s10  <= $signed({1'b0, v_s9}) * dmid;
			x0_s10   <= x0_s9;
			// Stage 11
			val_s11  <= x0_s10 + $signed(lp2_s10[35:16]);
			// Stage 12: weight by this octave's amplitude.
			term_s12 <= $signed({1'b0, carry_q[10].amp}) * val_s11;
			// Stage 13
			if (active) begin
				sum_s13 <= carry_q[11].sum + {{2{term_s12[40]}}, term_s12[40:16]};
			end else begin
				sum_s13 <= carry_q[11].sum;
			end
		end
	end

	always_comb begin
		link_out.valid = carry_q[NS-1].valid;
		link_out.sx    = carry_q[NS-1].sx;
		link_out.sy    = carry_q[NS-1].sy;
		link_out.freq  = fn_q[NS-2];
		link_out.amp   = an_q[NS-2];
		link_out.sum   = sum_s13;
	end

endmodule
`default_nettype wire

>>> rtl/fractal_gradient_noise_2d_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractal gradient noise, two dimensions
// Sums up to MAX_OCTAVES octaves of lattice gradient noise for a Q16.16
// point and returns a saturated Q8.16 value.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while the row advances. A sample passes
// a scaling stage, a row of MAX_OCTAVES octave cells of 13 stages each and an
// output register. The whole row advances together; it holds only while a
// result sits in the output register and the output side is not ready.
// Configuration must be written only when no samples are in flight.
module fractal_gradient_noise_2d_top #(
	parameter int MAX_OCTAVES = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [47:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [31:0]  point_x,
	input  wire logic signed [31:0]  point_y,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [23:0]       noise
);

	logic [2:0]  octave_count_q;
	logic [16:0] persistence_q;
	logic [19:0] lacunarity_q;
	logic [23:0] inverse_scale_q;
	logic [47:0] offset_q [4];

	logic              adv;
	logic [2:0]        count_eff;
	logic              out_valid_q;
	logic signed [23:0] noise_q;
	logic signed [23:0] sat;

	fgn_pkg::link_t chain [MAX_OCTAVES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q  <= 3'd4;
			persistence_q   <= 17'd32768;
			lacunarity_q    <= 20'd131072;
			inverse_scale_q <= 24'd65536;
			for (int i = 0; i < 4; i++) begin
				offset_q[i] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				fgn_pkg::REG_OCTAVE_COUNT: octave_count_q  <= cfg_data[2:0];
				fgn_pkg::REG_PERSISTENCE:  persistence_q   <= cfg_data[16:0];
				fgn_pkg::REG_LACUNARITY:   lacunarity_q    <= cfg_data[19:0];
				fgn_pkg::REG_INV_SCALE:    inverse_scale_q <= cfg_data[23:0];
				fgn_pkg::REG_OFFSET_0:     offset_q[0]     <= cfg_data;
				fgn_pkg::REG_OFFSET_1:     offset_q[1]     <= cfg_data;
				fgn_pkg::REG_OFFSET_2:     offset_q[2]     <= cfg_data;
				fgn_pkg::REG_OFFSET_3:     offset_q[3]     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign count_eff = (octave_count_q > 3'(MAX_OCTAVES)) ? 3'(MAX_OCTAVES) : octave_count_q;

	fgn_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.in_valid      (in_valid),
		.point_x       (point_x),
		.point_y       (point_y),
		.inverse_scale (inverse_scale_q),
		.link_out      (chain[0])
	);

	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
		fgn_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv),
			.active      (3'(k) < count_eff),
			.offset      (offset_q[k]),
			.lacunarity  (lacunarity_q),
			.persistence (persistence_q),
			.link_in     (chain[k]),
			.link_out    (chain[k+1])
		);
	end

	always_comb begin
		if (chain[MAX_OCTAVES].sum > 27'sd8388607) begin
			sat = 24'sh7F_FFFF;
		end else if (chain[MAX_OCTAVES].sum < -27'sd8388608) begin
			sat = 24'sh80_0000;
		end else begin
			sat = chain[MAX_OCTAVES].sum[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[MAX_OCTAVES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			noise_q <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign noise     = noise_q;

	// A held result freezes the last cell's output.
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(chain[MAX_OCTAVES]))
		else $error("octave row moved while the output was held");

	// A result only appears when the last cell delivered a sample.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(chain[MAX_OCTAVES].valid))
		else $error("result appeared without a sample from the octave row");

	// An octave count write lands in its register on the next cycle.
	a_cfg_count: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && cfg_index == fgn_pkg::REG_OCTAVE_COUNT
		|=> octave_count_q == $past(cfg_data[2:0]))
		else $error("octave count write lost");

endmodule
`default_nettype wire

>>> tb/sv/fgn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal gradient noise checker
// Watches the configuration port and both channels. It keeps its own copy of
// the registers, predicts the noise value of every accepted point and compares
// each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fgn_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [47:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [23:0] noise,
	output int                      fail_count,
	output int                      pending_count,
	output int                      seen_count
);

	logic [2:0]  oct_count;
	logic [16:0] persist;
	logic [19:0] lacun;
	logic [23:0] inv_scale;
	logic [47:0] oct_offset [4];

	logic signed [23:0] noise_queue [$];

	function automatic longint floor16(longint v);
		return v >>> 16;
	endfunction

	function automatic longint fade(longint t);
		longint ap;
		longint b;
		ap = 15 * 65536 - 6 * t;
		b = 655360 - ((t * ap + 65535) >>> 16);
		for (int k = 0; k < 3; k++)
			b = floor16(t * b);
		return b;
	endfunction

	function automatic longint gdot(logic [1:0] h, longint dx, longint dy);
		case (h)
			fgn_pkg::GRAD_PP: return dx + dy;
			fgn_pkg::GRAD_NP: return dy - dx;
			fgn_pkg::GRAD_PN: return dx - dy;
			default: return -dx - dy;
		endcase
	endfunction

	function automatic longint mix(longint a, longint b, longint w);
		return a + floor16(w * (b - a));
	endfunction

	function automatic longint lattice(logic [23:0] cx, logic [23:0] cy);
		logic [7:0] xi, yi, ra, rb;
		longint fx, fy, u, v;
		logic [7:0] h00, h01, h10, h11;
		xi = cx[23:16];
		yi = cy[23:16];
		fx = cx[15:0];
		fy = cy[15:0];
		u = fade(fx);
		v = fade(fy);
		ra = fgn_pkg::PERM_ROM[xi];
		rb = fgn_pkg::PERM_ROM[8'(xi + 8'd1)];
		h00 = fgn_pkg::PERM_ROM[8'(ra + yi)];
		h01 = fgn_pkg::PERM_ROM[8'(ra + yi + 8'd1)];
		h10 = fgn_pkg::PERM_ROM[8'(rb + yi)];
		h11 = fgn_pkg::PERM_ROM[8'(rb + yi + 8'd1)];
		return mix(mix(gdot(h00[1:0], fx, fy), gdot(h10[1:0], fx - 65536, fy), u),
			mix(gdot(h01[1:0], fx, fy - 65536), gdot(h11[1:0], fx - 65536, fy - 65536), u),
			v);
	endfunction

	function automatic logic signed [23:0] predict_noise(logic signed [31:0] px,
			logic signed [31:0] py);
		logic [63:0] sx, sy, freq, amp, cx, cy;
		longint sum;
		int count;
		sx = (64'($signed(px)) * 64'(inv_scale)) >> 16;
		sy = (64'($signed(py)) * 64'(inv_scale)) >> 16;
		count = (oct_count > 4) ? 4 : oct_count;
		freq = 65536;
		amp = 65536;
		sum = 0;
		for (int k = 0; k < count; k++) begin
			cx = (((sx * freq) >> 16) + 64'(oct_offset[k][47:24])) & 64'hFFFFFF;
			cy = (((sy * freq) >> 16) + 64'(oct_offset[k][23:0])) & 64'hFFFFFF;
			sum += floor16(longint'(amp) * lattice(cx[23:0], cy[23:0]));
			amp = (amp * 64'(persist)) >> 16;
			freq = (freq * 64'(lacun)) >> 16;
		end
		if (sum > 8388607) sum = 8388607;
		if (sum < -8388608) sum = -8388608;
		return sum[23:0];
	endfunction

	assign pending_count = noise_queue.size();

	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [23:0] want;
		if (!arst_n) begin
			oct_count <= 3'd4;
			persist <= 17'd32768;
			lacun <= 20'd131072;
			inv_scale <= 24'd65536;
			for (int k = 0; k < 4; k++)
				oct_offset[k] <= '0;
			fail_count <= 0;
			seen_count <= 0;
			noise_queue.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					fgn_pkg::REG_OCTAVE_COUNT: oct_count <= cfg_data[2:0];
					fgn_pkg::REG_PERSISTENCE:  persist <= cfg_data[16:0];
					fgn_pkg::REG_LACUNARITY:   lacun <= cfg_data[19:0];
					fgn_pkg::REG_INV_SCALE:    inv_scale <= cfg_data[23:0];
					default: oct_offset[cfg_index - fgn_pkg::REG_OFFSET_0] <= cfg_data;
				endcase
			end
			if (in_valid && in_ready)
				noise_queue.insert(noise_queue.size(), predict_noise(point_x, point_y));
			if (out_valid && out_ready) begin
				seen_count <= seen_count + 1;
				if (noise_queue.size() == 0) begin
					$display("%0t: noise with no sample waiting, actual %0d",
						$time, noise);
					fail_count <= fail_count + 1;
				end else begin
					want = noise_queue.pop_front();
					if (want !== noise) begin
						$display("%0t: noise mismatch, expected %0d actual %0d",
							$time, want, noise);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> tb/sv/tb_fractal_gradient_noise_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal gradient noise testbench
// Drives points through the noise block under several register settings and
// flow-control patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fractal_gradient_noise_2d_top;

	localparam int DRAIN_CYCLES = 13 * 4 + 10;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [47:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic               out_valid;
	logic               out_ready;
	logic signed [23:0] noise;
	int                 fail_count;
	int                 pending_count;
	int                 seen_count;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	bit                 recv_hold;
	int                 sent_count;

	fractal_gradient_noise_2d_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .out_valid(out_valid),
		.out_ready(out_ready), .noise(noise)
	);

	fgn_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .out_valid(out_valid),
		.out_ready(out_ready), .noise(noise),
		.fail_count(fail_count), .pending_count(pending_count),
		.seen_count(seen_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_fractal_gradient_noise_2d_top: errors");
		$finish;
	end

	// Receiver: random stalls, or a long hold when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One register write, after which the write strobe drops and the port goes quiet.
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// One point transfer, with a random gap before it.
	task automatic send_point(input logic [31:0] px, input logic [31:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2047)) - 1024) <<< 12;
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return {16'($urandom_range(300)), 16'($urandom)};
		endcase
	endfunction

	task automatic random_config();
		write_reg(fgn_pkg::REG_OCTAVE_COUNT, 48'($urandom_range(7)));
		write_reg(fgn_pkg::REG_PERSISTENCE, 48'($urandom_range(131071)));
		write_reg(fgn_pkg::REG_LACUNARITY, $urandom_range(1) ? 48'($urandom_range(1048575))
			: 48'($urandom_range(262144)));
		write_reg(fgn_pkg::REG_INV_SCALE, $urandom_range(1) ? 48'($urandom_range(16777215))
			: 48'($urandom_range(131072)));
		for (int k = 0; k < 4; k++)
			write_reg(fgn_pkg::REG_OFFSET_0 + 3'(k), {16'($urandom), 32'($urandom)});
	endtask

	initial begin
		logic [31:0] edge_vals [6];
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b0;
		sent_count = 0;
		edge_vals = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000,
			32'h0000FFFF};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: field extremes and corner points.
		foreach (edge_vals[i])
			send_point(edge_vals[i], edge_vals[(i + 3) % 6]);
		send_point(32'hFFFF8000, 32'h00018000);
		settle();

		// Zero octaves, then a count above the maximum.
		write_reg(fgn_pkg::REG_OCTAVE_COUNT, 48'd0);
		send_point(32'h12345678, 32'h87654321);
		settle();
		write_reg(fgn_pkg::REG_OCTAVE_COUNT, 48'd7);
		write_reg(fgn_pkg::REG_PERSISTENCE, 48'd131071);
		write_reg(fgn_pkg::REG_LACUNARITY, 48'd1048575);
		write_reg(fgn_pkg::REG_INV_SCALE, 48'd16777215);
		for (int k = 0; k < 4; k++)
			write_reg(fgn_pkg::REG_OFFSET_0 + 3'(k), 48'hFFFFFFFFFFFF);
		foreach (edge_vals[i])
			send_point(edge_vals[i], edge_vals[5 - i]);
		settle();

		// Zero inverse scale samples only the offsets; also the low extremes.
		write_reg(fgn_pkg::REG_INV_SCALE, 48'd0);
		write_reg(fgn_pkg::REG_PERSISTENCE, 48'd0);
		write_reg(fgn_pkg::REG_LACUNARITY, 48'd0);
		write_reg(fgn_pkg::REG_OCTAVE_COUNT, 48'd1);
		write_reg(fgn_pkg::REG_OFFSET_0, 48'h0080_0000_8000);
		send_point(32'h7FFFFFFF, 32'h80000000);
		send_point(32'h00000000, 32'hFFFFFFFF);
		settle();
		write_reg(fgn_pkg::REG_OCTAVE_COUNT, 48'd4);
		write_reg(fgn_pkg::REG_PERSISTENCE, 48'd65536);
		send_point(32'hABCDEF01, 32'h10FEDCBA);
		settle();

		// Random phases with various flow-control patterns.
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			random_config();
			for (int i = 0; i < 115; i++) begin
				if (ph == 5 && i == 20)
					recv_hold = 1'b1;
				send_point(rand_coord(), rand_coord());
			end
			if (ph == 9)
				settle();
			settle();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();

		$display("Ran %0d points over directed and 16 random register settings,", sent_count);
		$display("with idle, stall and back-pressure phases; %0d results checked.",
			seen_count);
		if (fail_count == 0 && pending_count == 0)
			$display("tb_fractal_gradient_noise_2d_top: clean");
		else
			$display("tb_fractal_gradient_noise_2d_top: errors");
		$finish;
	end

	// Long receiver hold-off, counted here, so the pipeline fills and stalls input.
	initial begin
		wait (recv_hold);
		repeat (400) @(posedge clk);
		recv_hold = 1'b0;
	end
endmodule
